[rtl/weighted_moving_average_filter_assert.svh]
// assertion macros for the weighted moving average filter
// expects i_clk and i_rst_n in the scope of each use
`ifndef WEIGHTED_MOVING_AVERAGE_FILTER_ASSERT_SVH
`define WEIGHTED_MOVING_AVERAGE_FILTER_ASSERT_SVH

// consequent checked in the same cycle as the antecedent
`define WMAF_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("wmaf: same-cycle check failed");

// consequent checked in the cycle after the antecedent
`define WMAF_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("wmaf: next-cycle check failed");

`endif

[rtl/wmaf_pkg.sv]
// shared types and constants of the weighted moving average filter
// no dependencies
package wmaf_pkg;

    localparam int SAMPLE_BITS = 12;
    localparam int COUNT_BITS  = 6;
    // ring depth and largest usable window
    localparam int MAX_WINDOW  = 32;
    // squared weight reaches 33*33 on the final increment
    localparam int WEIGHT_BITS = 13;
    // squared weight sum for 32 samples is 11440
    localparam int WSUM_BITS   = 17;
    localparam int ACC_BITS    = 32;
    // quotient magnitude never exceeds 2048
    localparam int QUO_BITS    = SAMPLE_BITS + 1;

    localparam int CFG_INDEX_BITS = 1;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_WINDOW_LEN  = 1'b0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_WEIGHT_MODE = 1'b1;

    localparam logic REQ_ADD   = 1'b0;
    localparam logic REQ_CLEAR = 1'b1;

    localparam logic MODE_LINEAR  = 1'b0;
    localparam logic MODE_SQUARED = 1'b1;

    localparam logic [COUNT_BITS-1:0] WINDOW_LEN_RESET = 6'd30;

    typedef struct packed {
        logic                          req_type;
        logic signed [SAMPLE_BITS-1:0] sample;
    } t_in_req;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] average;
        logic [COUNT_BITS-1:0]         fill_count;
    } t_out_res;

    typedef struct packed {
        logic                done;
        logic [QUO_BITS-1:0] quot;
    } t_div_res;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ACC,
        ST_DIV,
        ST_OUT
    } t_state;

endpackage

[rtl/wmaf_ram.sv]
// generic single-port-write, single-port-read ram with registered read data
// no dependencies
module wmaf_ram #(
    parameter int WIDTH = 12,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/wmaf_div.sv]
// restoring divider, one quotient bit per cycle, unsigned operands
// depends on wmaf_pkg
module wmaf_div (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [wmaf_pkg::ACC_BITS-1:0]  i_dividend,
    input  logic [wmaf_pkg::WSUM_BITS-1:0] i_divisor,
    output wmaf_pkg::t_div_res             o_res
);

    localparam int CNT_W = $clog2(wmaf_pkg::QUO_BITS + 1);

    logic                           r_busy;
    logic                           r_done;
    logic [CNT_W-1:0]               r_cnt;
    logic [wmaf_pkg::WSUM_BITS-1:0] r_rem;
    logic [wmaf_pkg::WSUM_BITS-1:0] r_dsr;
    logic [wmaf_pkg::QUO_BITS-1:0]  r_lo;

    logic [wmaf_pkg::WSUM_BITS:0]   w_trial;
    logic                           w_ge;

    assign w_trial = {r_rem, r_lo[wmaf_pkg::QUO_BITS-1]};
    assign w_ge    = (w_trial >= {1'b0, r_dsr});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                // dividend < divisor * 2^QUO_BITS, so the high part starts below the divisor
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(wmaf_pkg::QUO_BITS);
                r_rem  <= wmaf_pkg::WSUM_BITS'(i_dividend >> wmaf_pkg::QUO_BITS);
                r_lo   <= i_dividend[wmaf_pkg::QUO_BITS-1:0];
                r_dsr  <= i_divisor;
            end else if (r_busy) begin
                r_rem <= w_ge ? wmaf_pkg::WSUM_BITS'(w_trial - {1'b0, r_dsr})
                              : wmaf_pkg::WSUM_BITS'(w_trial);
                r_lo  <= {r_lo[wmaf_pkg::QUO_BITS-2:0], w_ge};
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_res.done = r_done;
    assign o_res.quot = r_lo;

endmodule

[rtl/weighted_moving_average_filter.sv]
// top level of the weighted moving average filter: window bookkeeping,
// accumulation sequencer and output register; depends on wmaf_pkg, wmaf_ram, wmaf_div
//
//  channel | direction | handshake            | payload
//  in      | input     | i_in_valid/o_in_stall | i_in_data  (wmaf_pkg::t_in_req)
//  out     | output    | o_out_valid/i_out_stall| o_out_data (wmaf_pkg::t_out_res)
//  cfg     | input     | i_cfg_we             | i_cfg_index, i_cfg_wdata
//
// an add request walks the sample ram one read a cycle over the n held samples, n being
// the fill count after it, then the divider retires one quotient bit a cycle over 13
// steps; a clear request skips both and goes straight to the output state
// one request is worked on at a time; o_in_stall is high from acceptance until the
// result has moved into the output register, which holds it while i_out_stall is high
// reset is synchronous, active low, and empties the window
`include "weighted_moving_average_filter_assert.svh"

module weighted_moving_average_filter (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  wmaf_pkg::t_in_req                   i_in_data,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output wmaf_pkg::t_out_res                  o_out_data,
    input  logic                                i_cfg_we,
    input  logic [wmaf_pkg::CFG_INDEX_BITS-1:0] i_cfg_index,
    input  logic [wmaf_pkg::COUNT_BITS-1:0]     i_cfg_wdata
);

    localparam int MAX_WINDOW = wmaf_pkg::MAX_WINDOW;
    localparam int AW   = $clog2(MAX_WINDOW);
    localparam int CW   = $clog2(MAX_WINDOW + 1);
    localparam int CMPW = (CW > wmaf_pkg::COUNT_BITS) ? CW : wmaf_pkg::COUNT_BITS;
    localparam int SW   = CMPW + 1;
    localparam int HW   = wmaf_pkg::COUNT_BITS + 1;

    // ring index a + b, with a below the depth and b no larger than it
    function automatic logic [AW-1:0] f_wrap(input logic [AW-1:0] a, input logic [HW-1:0] b);
        logic [SW-1:0] s;
        s = SW'(a) + SW'(b);
        if (s >= SW'(MAX_WINDOW)) begin
            s = s - SW'(MAX_WINDOW);
        end
        return AW'(s);
    endfunction

    wmaf_pkg::t_state               r_state, n_state;
    logic [wmaf_pkg::COUNT_BITS-1:0] r_window_len;
    logic                            r_weight_mode;
    logic [wmaf_pkg::COUNT_BITS-1:0] r_held;
    logic [AW-1:0]                   r_oldest;

    logic [AW-1:0]                   r_raddr;
    logic [wmaf_pkg::COUNT_BITS-1:0] r_idx;
    logic                            r_rvld;
    logic [wmaf_pkg::WEIGHT_BITS-1:0] r_w;
    logic [wmaf_pkg::WEIGHT_BITS-1:0] r_wsq;
    logic [wmaf_pkg::WEIGHT_BITS-1:0] r_rwt;
    logic signed [wmaf_pkg::ACC_BITS-1:0] r_acc;
    logic [wmaf_pkg::WSUM_BITS-1:0]  r_wsum;
    logic                            r_neg;
    wmaf_pkg::t_out_res              r_res;
    wmaf_pkg::t_out_res              r_out;
    logic                            r_out_vld;

    logic                            w_in_acc;
    logic                            w_clear;
    logic                            w_full;
    logic [HW-1:0]                   w_h1;
    logic [HW-1:0]                   w_h2;
    logic [AW-1:0]                   w_o1;
    logic [AW-1:0]                   w_waddr;
    logic [wmaf_pkg::COUNT_BITS-1:0] w_len;
    logic [wmaf_pkg::COUNT_BITS-1:0] n_held;
    logic [AW-1:0]                   n_oldest;
    logic                            w_issue;
    logic                            w_div_start;
    logic                            w_out_load;
    logic [wmaf_pkg::SAMPLE_BITS-1:0] w_rdata;
    logic signed [wmaf_pkg::SAMPLE_BITS+wmaf_pkg::WEIGHT_BITS:0] w_prod;
    logic [wmaf_pkg::ACC_BITS-1:0]   w_mag;
    logic [wmaf_pkg::QUO_BITS-1:0]   w_avg;
    wmaf_pkg::t_div_res              w_div;

    assign o_in_stall = (r_state != wmaf_pkg::ST_IDLE);
    assign w_in_acc   = i_in_valid && !o_in_stall;
    assign w_clear    = (i_in_data.req_type == wmaf_pkg::REQ_CLEAR);

    // window bookkeeping for an add request
    always_comb begin
        w_full = (CMPW'(r_held) >= CMPW'(MAX_WINDOW));
        w_h1   = w_full ? HW'(r_held) - 1'b1 : HW'(r_held);
        w_o1   = w_full ? f_wrap(r_oldest, HW'(1)) : r_oldest;
        w_waddr = f_wrap(w_o1, w_h1);
        w_h2   = w_h1 + 1'b1;
        if (r_window_len == '0) begin
            w_len = wmaf_pkg::COUNT_BITS'(1);
        end else if (CMPW'(r_window_len) > CMPW'(MAX_WINDOW)) begin
            w_len = wmaf_pkg::COUNT_BITS'(MAX_WINDOW);
        end else begin
            w_len = r_window_len;
        end
        if (w_h2 > HW'(w_len)) begin
            // window shrunk or full: keep only the newest w_len samples
            n_held   = w_len;
            n_oldest = f_wrap(w_o1, w_h2 - HW'(w_len));
        end else begin
            n_held   = wmaf_pkg::COUNT_BITS'(w_h2);
            n_oldest = w_o1;
        end
    end

    assign w_issue = (r_state == wmaf_pkg::ST_ACC) && (r_idx != r_held);

    always_comb begin
        n_state     = r_state;
        w_div_start = 1'b0;
        w_out_load  = 1'b0;
        case (r_state)
            wmaf_pkg::ST_IDLE: begin
                if (w_in_acc) begin
                    n_state = w_clear ? wmaf_pkg::ST_OUT : wmaf_pkg::ST_ACC;
                end
            end
            wmaf_pkg::ST_ACC: begin
                if ((r_idx == r_held) && !r_rvld) begin
                    n_state     = wmaf_pkg::ST_DIV;
                    w_div_start = 1'b1;
                end
            end
            wmaf_pkg::ST_DIV: begin
                if (w_div.done) begin
                    n_state = wmaf_pkg::ST_OUT;
                end
            end
            wmaf_pkg::ST_OUT: begin
                if (!r_out_vld || !i_out_stall) begin
                    n_state    = wmaf_pkg::ST_IDLE;
                    w_out_load = 1'b1;
                end
            end
            default: begin
                n_state = wmaf_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= wmaf_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    wmaf_ram #(
        .WIDTH (wmaf_pkg::SAMPLE_BITS),
        .DEPTH (MAX_WINDOW)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_in_acc && !w_clear),
        .i_waddr (w_waddr),
        .i_wdata (i_in_data.sample),
        .i_raddr (r_raddr),
        .o_rdata (w_rdata)
    );

    assign w_prod = $signed(w_rdata) * $signed({1'b0, r_rwt});
    assign w_mag  = r_acc[wmaf_pkg::ACC_BITS-1] ? wmaf_pkg::ACC_BITS'(-r_acc)
                                                : wmaf_pkg::ACC_BITS'(r_acc);
    assign w_avg  = r_neg ? -w_div.quot : w_div.quot;

    wmaf_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_mag),
        .i_divisor  (r_wsum),
        .o_res      (w_div)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_len  <= wmaf_pkg::WINDOW_LEN_RESET;
            r_weight_mode <= wmaf_pkg::MODE_LINEAR;
            r_held        <= '0;
            r_oldest      <= '0;
            r_rvld        <= 1'b0;
            r_out_vld     <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    wmaf_pkg::CFG_WINDOW_LEN:  r_window_len  <= i_cfg_wdata;
                    wmaf_pkg::CFG_WEIGHT_MODE: r_weight_mode <= i_cfg_wdata[0];
                    default: ;
                endcase
            end

            if (w_in_acc) begin
                if (w_clear) begin
                    r_held           <= '0;
                    r_oldest         <= '0;
                    r_res.average    <= '0;
                    r_res.fill_count <= '0;
                end else begin
                    r_held           <= n_held;
                    r_oldest         <= n_oldest;
                    r_res.fill_count <= n_held;
                    // walk starts at the oldest slot with weight one
                    r_raddr <= n_oldest;
                    r_idx   <= '0;
                    r_w     <= wmaf_pkg::WEIGHT_BITS'(1);
                    r_wsq   <= wmaf_pkg::WEIGHT_BITS'(1);
                    r_acc   <= '0;
                    r_wsum  <= '0;
                end
            end

            r_rvld <= w_issue;
            if (w_issue) begin
                r_raddr <= f_wrap(r_raddr, HW'(1));
                r_idx   <= r_idx + 1'b1;
                r_rwt   <= (r_weight_mode == wmaf_pkg::MODE_SQUARED) ? r_wsq : r_w;
                r_w     <= r_w + 1'b1;
                // (w+1)^2 = w^2 + 2w + 1
                r_wsq   <= r_wsq + wmaf_pkg::WEIGHT_BITS'({r_w, 1'b1});
            end

            if (r_rvld) begin
                r_acc  <= r_acc + wmaf_pkg::ACC_BITS'(w_prod);
                r_wsum <= r_wsum + wmaf_pkg::WSUM_BITS'(r_rwt);
            end

            if (w_div_start) begin
                r_neg <= r_acc[wmaf_pkg::ACC_BITS-1];
            end

            if ((r_state == wmaf_pkg::ST_DIV) && w_div.done) begin
                r_res.average <= wmaf_pkg::SAMPLE_BITS'(w_avg);
            end

            if (w_out_load) begin
                r_out_vld <= 1'b1;
                r_out     <= r_res;
            end else if (!i_out_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

    `WMAF_ASSERT_SAME(a_held_in_range, 1'b1, CMPW'(r_held) <= CMPW'(MAX_WINDOW))
    `WMAF_ASSERT_SAME(a_walk_bounded, r_state == wmaf_pkg::ST_ACC, r_idx <= r_held)
    `WMAF_ASSERT_SAME(a_div_done_in_div, w_div.done, r_state == wmaf_pkg::ST_DIV)
    `WMAF_ASSERT_NEXT(a_clear_empties, w_in_acc && w_clear, r_held == '0 && r_oldest == '0)

endmodule

[bench/wmaf_average_checker.sv]
// checker for the weighted moving average filter: watches the request, result and
// register write ports, predicts each average and fill count and compares them; depends on wmaf_pkg
module wmaf_average_checker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    input  logic                                i_in_stall,
    input  wmaf_pkg::t_in_req                   i_in_data,
    input  logic                                i_out_valid,
    input  logic                                i_out_stall,
    input  wmaf_pkg::t_out_res                  i_out_data,
    input  logic                                i_cfg_we,
    input  logic [wmaf_pkg::CFG_INDEX_BITS-1:0] i_cfg_index,
    input  logic [wmaf_pkg::COUNT_BITS-1:0]     i_cfg_wdata,
    output int                                  o_fail_count,
    output int                                  o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_WINDOW = wmaf_pkg::MAX_WINDOW;

    logic signed [wmaf_pkg::SAMPLE_BITS-1:0] window_ring [MAX_WINDOW];
    int unsigned                   ring_head;
    int unsigned                   ring_fill;
    logic [wmaf_pkg::COUNT_BITS-1:0] cfg_len;
    logic                          cfg_mode;

    wmaf_pkg::t_out_res expected_averages [$];
    wmaf_pkg::t_out_res want;
    int       mismatch_total = 0;
    int       results_seen = 0;

    function automatic void retire_oldest();
        ring_head = (ring_head + 1) % MAX_WINDOW;
        ring_fill--;
    endfunction

    function automatic wmaf_pkg::t_out_res advance_window(wmaf_pkg::t_in_req req);
        wmaf_pkg::t_out_res res;
        int unsigned span;
        int unsigned k;
        longint      weighted_total;
        longint      wt_total;
        longint      wt;
        longint      quot;
        res = '0;
        if (req.req_type == wmaf_pkg::REQ_CLEAR) begin
            ring_head = 0;
            ring_fill = 0;
            return res;
        end
        if (ring_fill >= MAX_WINDOW)
            retire_oldest();
        window_ring[(ring_head + ring_fill) % MAX_WINDOW] = req.sample;
        ring_fill++;
        // zero means one, anything past the ring size means the whole ring
        span = (cfg_len == 0) ? 1 : ((cfg_len > MAX_WINDOW) ? MAX_WINDOW : cfg_len);
        while (ring_fill > span)
            retire_oldest();
        weighted_total = 0;
        wt_total = 0;
        for (k = 0; k < ring_fill; k++) begin
            wt = k + 1;
            if (cfg_mode == wmaf_pkg::MODE_SQUARED)
                wt = wt * wt;
            weighted_total += longint'(window_ring[(ring_head + k) % MAX_WINDOW]) * wt;
            wt_total += wt;
        end
        // integer division truncates toward zero
        quot = weighted_total / wt_total;
        res.average = quot[wmaf_pkg::SAMPLE_BITS-1:0];
        res.fill_count = ring_fill[wmaf_pkg::COUNT_BITS-1:0];
        return res;
    endfunction

    task automatic report_mismatch(string what, int got, int exp_val);
        $display("mismatch at result %0d: %s got %0d expected %0d",
                 results_seen, what, got, exp_val);
        mismatch_total++;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            ring_head = 0;
            ring_fill = 0;
            cfg_len = wmaf_pkg::WINDOW_LEN_RESET;
            cfg_mode = wmaf_pkg::MODE_LINEAR;
            expected_averages.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (expected_averages.size() == 0) begin
                    report_mismatch("result with no request pending",
                                    int'(i_out_data.average), 0);
                end else begin
                    want = expected_averages[0];
                    expected_averages.delete(0);
                    if (i_out_data.average !== want.average)
                        report_mismatch("average", int'(i_out_data.average),
                                        int'(want.average));
                    if (i_out_data.fill_count !== want.fill_count)
                        report_mismatch("fill_count", int'(i_out_data.fill_count),
                                        int'(want.fill_count));
                end
                results_seen++;
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    wmaf_pkg::CFG_WINDOW_LEN:  cfg_len = i_cfg_wdata;
                    wmaf_pkg::CFG_WEIGHT_MODE: cfg_mode = i_cfg_wdata[0];
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall)
                expected_averages.insert(expected_averages.size(),
                                         advance_window(i_in_data));
        end
        o_pending <= expected_averages.size();
        o_fail_count <= mismatch_total;
    end

endmodule

[bench/tb_weighted_moving_average_filter.sv]
// top of the weighted moving average filter bench: clock, reset, request and
// register stimulus, verdict; depends on wmaf_pkg, the filter and wmaf_average_checker
module tb_weighted_moving_average_filter;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD     = 4;
    localparam int ITEM_TARGET    = 1850;
    localparam int SETTLE_CYCLES  = 64;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int IDLE_PERCENT   = 31;

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      in_valid = 1'b0;
    logic                      in_stall;
    wmaf_pkg::t_in_req         in_data = '0;
    logic                      out_valid;
    logic                      out_stall = 1'b0;
    wmaf_pkg::t_out_res        out_data;
    logic                      cfg_we = 1'b0;
    logic [wmaf_pkg::CFG_INDEX_BITS-1:0] cfg_index = wmaf_pkg::CFG_WINDOW_LEN;
    logic [wmaf_pkg::COUNT_BITS-1:0]     cfg_wdata = '0;
    logic                      idle_enable = 1'b1;
    int                        fail_count;
    int                        pending;

    always #(CLK_PERIOD / 2) clk = ~clk;

    weighted_moving_average_filter dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_wdata (cfg_wdata)
    );

    wmaf_average_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in_data    (in_data),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out_data   (out_data),
        .i_cfg_we     (cfg_we),
        .i_cfg_index  (cfg_index),
        .i_cfg_wdata  (cfg_wdata),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always @(posedge clk) begin
        out_stall <= idle_enable && ($urandom_range(99) < IDLE_PERCENT);
    end

    initial begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT) begin
            @(posedge clk);
            if (!rst_n || cfg_we || (in_valid && !in_stall) || (out_valid && !out_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("status: fail");
        $finish;
    end

    function automatic logic [wmaf_pkg::SAMPLE_BITS-1:0] pick_sample();
        case ($urandom_range(9))
            0:       return 12'h7FF;
            1:       return 12'h800;
            2:       return 12'($urandom_range(16)) - 12'd8;
            default: return 12'($urandom);
        endcase
    endfunction

    // valid stays up after acceptance so back-to-back requests need no toggle
    task automatic send_request(logic kind, logic [wmaf_pkg::SAMPLE_BITS-1:0] value);
        wmaf_pkg::t_in_req req;
        req.req_type = kind;
        req.sample = value;
        if (idle_enable && $urandom_range(99) < IDLE_PERCENT) begin
            in_valid <= 1'b0;
            in_data <= wmaf_pkg::t_in_req'($urandom);
            do @(posedge clk); while ($urandom_range(99) < IDLE_PERCENT);
        end
        in_valid <= 1'b1;
        in_data <= req;
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    // drop valid and let the last result drain before touching registers
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic load_settings(logic [wmaf_pkg::COUNT_BITS-1:0] len, logic mode);
        cfg_we <= 1'b1;
        cfg_index <= wmaf_pkg::CFG_WINDOW_LEN;
        cfg_wdata <= len;
        @(posedge clk);
        cfg_index <= wmaf_pkg::CFG_WEIGHT_MODE;
        cfg_wdata <= {5'($urandom), mode};
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    initial begin
        int                    sent;
        int                    phase_len;
        logic [wmaf_pkg::COUNT_BITS-1:0] len_pick;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings, extremes of the sample range
        send_request(wmaf_pkg::REQ_ADD, 12'h7FF);
        send_request(wmaf_pkg::REQ_ADD, 12'h7FF);
        send_request(wmaf_pkg::REQ_ADD, 12'h800);
        send_request(wmaf_pkg::REQ_ADD, 12'h800);
        send_request(wmaf_pkg::REQ_ADD, 12'h000);
        send_request(wmaf_pkg::REQ_ADD, 12'hFFF);
        send_request(wmaf_pkg::REQ_ADD, 12'h001);
        // clear ignores its sample
        send_request(wmaf_pkg::REQ_CLEAR, 12'h7FF);
        send_request(wmaf_pkg::REQ_ADD, 12'h123);

        settle();
        load_settings(6'd1, wmaf_pkg::MODE_LINEAR);
        send_request(wmaf_pkg::REQ_ADD, 12'h800);
        send_request(wmaf_pkg::REQ_ADD, 12'h7FF);

        // zero length behaves as one
        settle();
        load_settings(6'd0, wmaf_pkg::MODE_LINEAR);
        send_request(wmaf_pkg::REQ_ADD, 12'h005);
        send_request(wmaf_pkg::REQ_ADD, 12'hFF9);

        // length beyond the ring, squared weights
        settle();
        load_settings(6'd63, wmaf_pkg::MODE_SQUARED);
        send_request(wmaf_pkg::REQ_ADD, 12'h800);
        send_request(wmaf_pkg::REQ_ADD, 12'h800);
        send_request(wmaf_pkg::REQ_ADD, 12'h800);
        send_request(wmaf_pkg::REQ_ADD, 12'h7FF);
        send_request(wmaf_pkg::REQ_CLEAR, 12'hFFF);
        send_request(wmaf_pkg::REQ_ADD, 12'd1000);
        send_request(wmaf_pkg::REQ_ADD, 12'hF01);
        send_request(wmaf_pkg::REQ_ADD, 12'd77);

        // window shrunk under a fuller ring
        settle();
        load_settings(6'd2, wmaf_pkg::MODE_LINEAR);
        send_request(wmaf_pkg::REQ_ADD, 12'hFFD);
        send_request(wmaf_pkg::REQ_ADD, 12'h7FF);

        sent = 0;
        while (sent < ITEM_TARGET) begin
            settle();
            idle_enable <= !(sent >= 800 && sent < 1100);
            case ($urandom_range(7))
                0:       len_pick = 6'd0;
                1:       len_pick = 6'd1;
                2:       len_pick = 6'd32;
                3:       len_pick = 6'd33;
                4:       len_pick = 6'd63;
                default: len_pick = 6'($urandom_range(32, 1));
            endcase
            load_settings(len_pick, 1'($urandom_range(1)));
            phase_len = $urandom_range(90, 8);
            repeat (phase_len) begin
                if ($urandom_range(99) < 3)
                    send_request(wmaf_pkg::REQ_CLEAR, 12'($urandom));
                else
                    send_request(wmaf_pkg::REQ_ADD, pick_sample());
                sent++;
            end
        end

        settle();
        if (fail_count == 0 && pending == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
